@@ rtl/b2da_pkg.sv @@
// Shared constants and the BCD digit correction function for the decimal converter.
`default_nettype none

package b2da_pkg;

    localparam int unsigned BIN_W      = 64;
    localparam int unsigned NUM_DIGITS = 20;
    localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
    localparam int unsigned ITER_W     = $clog2(BIN_W);
    localparam int unsigned DCNT_W     = $clog2(NUM_DIGITS + 1);
    localparam int unsigned CHAR_W     = 6;

    // Upper two bits of the ASCII code for '0' to '9', after masking to six bits.
    localparam logic [1:0] ASCII_DIGIT_HI = 2'b11;

    typedef logic [BCD_W-1:0] bcd_t;

    // Adds three to every BCD digit that is five or more, ready for the next shift.
    function automatic bcd_t bcd_correct(input bcd_t value);
        bcd_t       result;
        logic [3:0] nib;
        result = value;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            nib = value[4*i +: 4];
            if (nib >= 4'd5)
            begin
                result[4*i +: 4] = nib + 4'd3;
            end
        end
        return result;
    endfunction

endpackage

`default_nettype wire

@@ rtl/binary_to_decimal_ascii.sv @@
// Converter from an unsigned 64-bit binary value to a stream of ASCII decimal digits.
`default_nettype none

// Each accepted item is an unsigned 64-bit number; the block returns its decimal
// text as one item per ASCII digit, most significant digit first, with no leading
// zeros, and marks the final digit with is_last. Zero gives the single digit '0',
// and the largest value gives twenty digits. The conversion runs a shift-and-add-3
// loop over one 80-bit BCD register, one input bit per cycle, taking the most
// significant bit first. Leading zero digits are then dropped one per cycle (up to
// 19 of them), the skip state then finds the first digit to keep, and the remaining
// digits are offered one per cycle while out_stall is low. The block takes no new
// item before the final digit of the current one has been taken; the next item is
// taken no earlier than the cycle after that. in_stall is high from the cycle after
// an item is accepted until its final digit has been taken.

module binary_to_decimal_ascii
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [b2da_pkg::BIN_W-1:0]         number,

    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [b2da_pkg::CHAR_W-1:0]             digit_char,
    output logic                                    is_last
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_EMIT
    } state_t;

    state_t                              state_reg,  state_next;
    logic [b2da_pkg::BIN_W-1:0]          bin_reg,    bin_next;
    b2da_pkg::bcd_t                      bcd_reg,    bcd_next;
    logic [b2da_pkg::ITER_W-1:0]         iter_reg,   iter_next;
    logic [b2da_pkg::DCNT_W-1:0]         digits_reg, digits_next;

    logic [3:0]                          top_digit;
    b2da_pkg::bcd_t                      bcd_fixed;

    // The digit on show is always the top nibble of the BCD register.
    assign top_digit  = bcd_reg[b2da_pkg::BCD_W-1 -: 4];

    // Every digit of five or more corrected, ready for the next shift.
    assign bcd_fixed  = b2da_pkg::bcd_correct(bcd_reg);

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = (state_reg == ST_EMIT);
    assign digit_char = {b2da_pkg::ASCII_DIGIT_HI, top_digit};
    assign is_last    = (digits_reg == b2da_pkg::DCNT_W'(1));

    always_comb
    begin
        state_next  = state_reg;
        bin_next    = bin_reg;
        bcd_next    = bcd_reg;
        iter_next   = iter_reg;
        digits_next = digits_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    bin_next   = number;
                    bcd_next   = '0;
                    iter_next  = '0;
                    state_next = ST_CONVERT;
                end
            end

            ST_CONVERT:
            begin
                // Correct every digit, then shift the next binary bit in at the bottom.
                bcd_next  = {bcd_fixed[b2da_pkg::BCD_W-2:0], bin_reg[b2da_pkg::BIN_W-1]};
                bin_next  = {bin_reg[b2da_pkg::BIN_W-2:0], 1'b0};
                iter_next = iter_reg + 1'b1;
                if (iter_reg == {b2da_pkg::ITER_W{1'b1}})
                begin
                    digits_next = b2da_pkg::DCNT_W'(b2da_pkg::NUM_DIGITS);
                    state_next  = ST_SKIP;
                end
            end

            ST_SKIP:
            begin
                // Drop leading zeros, but always keep the final digit.
                if ((top_digit == 4'd0) && !is_last)
                begin
                    bcd_next    = {bcd_reg[b2da_pkg::BCD_W-5:0], 4'd0};
                    digits_next = digits_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        bcd_next    = {bcd_reg[b2da_pkg::BCD_W-5:0], 4'd0};
                        digits_next = digits_reg - 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            iter_reg   <= '0;
            digits_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            iter_reg   <= iter_next;
            digits_reg <= digits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the 64-bit binary to decimal ASCII digit converter.

localparam int unsigned DECIMAL_BASE = 10;
localparam int unsigned ASCII_ZERO   = 48;
localparam int unsigned CHAR_BITS    = b2da_pkg::CHAR_W;
localparam int unsigned MAX_REPORTS  = 10;

typedef logic [CHAR_BITS-1:0] char_t;

// One expected digit, with the number that produced it for the error report.
typedef struct packed
{
    logic [63:0] source;
    char_t       ch;
    logic        last;
} digit_item_t;

// Turns each accepted number into its expected digit items and checks
// the digits that the block returns against them, oldest first.
class digit_scoreboard;
    digit_item_t expected_q[$];
    int unsigned mismatches;

    function new();
        mismatches = 0;
    endfunction

    function void report(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endfunction

    // Digits are found least significant first and then queued most
    // significant first; the loop body runs once even for zero.
    function void note_number(input logic [63:0] value);
        logic [63:0] rest;
        char_t       chars[$];
        digit_item_t item;
        rest = value;
        do
        begin
            chars.push_front(char_t'(ASCII_ZERO + (rest % DECIMAL_BASE)));
            rest = rest / DECIMAL_BASE;
        end
        while (rest != 0);
        foreach (chars[i])
        begin
            item.source = value;
            item.ch     = chars[i];
            item.last   = (i == chars.size() - 1);
            expected_q.push_back(item);
        end
    endfunction

    function void check_char(input char_t ch, input logic last);
        digit_item_t want;
        if (expected_q.size() == 0)
        begin
            report($sformatf("unexpected digit 0x%0h is_last %0b", ch, last));
            return;
        end
        want = expected_q.pop_front();
        if (ch !== want.ch || last !== want.last)
        begin
            report($sformatf("number %0d: expected digit 0x%0h is_last %0b, got 0x%0h is_last %0b",
                             want.source, want.ch, want.last, ch, last));
        end
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    function int unsigned error_count();
        return mismatches;
    endfunction
endclass

module testbench;

    // Percentage of cycles in which each side idles when idling is allowed.
    localparam int unsigned IDLE_PERCENT  = 14;
    localparam int unsigned RANDOM_ITEMS  = 400;
    // Random items in this window run with no idling on either side.
    localparam int unsigned QUIET_FIRST   = 150;
    localparam int unsigned QUIET_LAST    = 230;
    // Item at which the sender holds off until every digit has come back.
    localparam int unsigned HOLD_ITEM     = 300;
    // Extra wait after the final drain, so that any late output is still caught.
    localparam int unsigned DRAIN_CYCLES  = 200;
    // Far beyond the slowest legal run.
    localparam int unsigned RUN_LIMIT     = 2000000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] number;
    logic        out_valid;
    logic        out_stall;
    char_t       digit_char;
    logic        is_last;
    logic        quiet_mode;

    digit_scoreboard sb;

    binary_to_decimal_ascii u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .number     (number),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .is_last    (is_last)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Hard limit on the run, should the block hang.
    initial
    begin
        #(RUN_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // 10 to the power k, wrapping at 64 bits, for k up to 19.
    function automatic logic [63:0] pow10(input int unsigned k);
        logic [63:0] acc;
        acc = 64'd1;
        for (int unsigned i = 0; i < k; i++)
        begin
            acc = acc * DECIMAL_BASE;
        end
        return acc;
    endfunction

    // Random numbers are spread over every digit count: uniform values
    // almost always have 19 or 20 digits, so most are shortened by a random
    // shift or placed next to a power of ten where the digit count changes.
    function automatic logic [63:0] random_number();
        logic [63:0]  raw;
        logic [63:0]  base;
        int unsigned  sel;
        raw = {$urandom, $urandom};
        sel = $urandom_range(99);
        if (sel < 35)
        begin
            return raw >> $urandom_range(63);
        end
        else if (sel < 55)
        begin
            return raw;
        end
        else if (sel < 80)
        begin
            base = pow10($urandom_range(19));
            if ($urandom_range(1) == 0)
            begin
                return base - $urandom_range(2);
            end
            return base + $urandom_range(2);
        end
        return 64'($urandom_range(1000));
    endfunction

    // Offers one number at a falling edge, optionally after idling at
    // random, and holds it until a rising edge finds in_stall low.
    // in_valid drops at the falling edge after the item is taken, so a
    // waiting offer never changes its payload.
    task automatic send_number(input logic [63:0] value);
        while (!quiet_mode && $urandom_range(99) < IDLE_PERCENT)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        number   <= value;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        sb.note_number(value);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Drops in_valid and waits until every expected digit has been taken.
    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // The receiver stalls at random, except in the quiet window.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= !quiet_mode && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Every digit taken by the receiver goes straight to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_char(digit_char, is_last);
        end
    end

    initial
    begin
        logic [63:0] directed_q[$];

        sb         = new();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        number     = 64'd0;
        quiet_mode = 1'b0;

        repeat (6)
        begin
            @(negedge clk);
        end
        rst_n <= 1'b1;

        // Directed part: zero giving the single digit '0', one-digit and
        // two-digit edges, the step from 19 to 20 digits, the largest value
        // giving twenty digits, and alternating bit patterns.
        directed_q.push_back(64'd0);
        directed_q.push_back(64'd1);
        directed_q.push_back(64'd9);
        directed_q.push_back(64'd10);
        directed_q.push_back(64'd42);
        directed_q.push_back(64'd99);
        directed_q.push_back(64'd100);
        directed_q.push_back(pow10(9));
        directed_q.push_back(pow10(18));
        directed_q.push_back(pow10(19) - 64'd1);
        directed_q.push_back(pow10(19));
        directed_q.push_back(64'd12345678901234567890);
        directed_q.push_back({1'b0, {63{1'b1}}});
        directed_q.push_back({1'b1, {63{1'b0}}});
        directed_q.push_back({{63{1'b1}}, 1'b0});
        directed_q.push_back({64{1'b1}});
        directed_q.push_back({32{2'b01}});
        directed_q.push_back({32{2'b10}});
        directed_q.push_back(64'h0123_4567_89AB_CDEF);
        foreach (directed_q[i])
        begin
            send_number(directed_q[i]);
        end

        // Hold the sender back until the directed digits are all out.
        wait_for_drain();

        for (int unsigned n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet_mode = (n >= QUIET_FIRST && n <= QUIET_LAST);
            if (n == HOLD_ITEM)
            begin
                wait_for_drain();
            end
            send_number(random_number());
        end
        quiet_mode = 1'b0;

        wait_for_drain();
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end

        if (sb.error_count() == 0 && sb.pending() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/b2da_pkg.sv
rtl/binary_to_decimal_ascii.sv
tb/testbench.sv
